// File: sv/gbpb_pkg.sv
package gbpb_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_PAGES  = 8;
  localparam int FONT_BYTES = 2048;
  localparam int MAX_GLYPH  = 8;

  localparam int FONT_AW   = $clog2(FONT_BYTES);
  localparam int RES_DEPTH = MAX_GLYPH * MAX_GLYPH;
  localparam int RES_AW    = $clog2(RES_DEPTH);
  localparam int CUR_W     = 16;
  localparam int COL_W     = 8;
  localparam int IDX_W     = 10;
  localparam int RES_W     = IDX_W + 8;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] SCROLL_MAX = 8'd100;
  localparam logic [7:0] BLANK_BYTE = 8'h00;

  typedef enum logic [2:0] {
    ACT_RENDER = 3'd0,
    ACT_LOAD   = 3'd1,
    ACT_CURSOR = 3'd2,
    ACT_SCROLL = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    CFG_DISPLAY_WIDTH = 3'd0,
    CFG_DISPLAY_PAGES = 3'd1,
    CFG_FONT_FIRST    = 3'd2,
    CFG_FONT_COUNT    = 3'd3,
    CFG_GLYPH_WIDTH   = 3'd4,
    CFG_GLYPH_HEIGHT  = 3'd5,
    CFG_BOX_BEGIN     = 3'd6,
    CFG_BOX_END       = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_BASE1, ST_BASE2, ST_SYNC, ST_WAIT, ST_START,
    ST_FETCH, ST_BYTE, ST_CHK, ST_OVF, ST_ROWEND, ST_FINAL, ST_NL, ST_CR,
    ST_OUT, ST_LD, ST_SEND
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CUR_W-1:0] dividend;
    logic [COL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [CUR_W-1:0] quo;
    logic [COL_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: sv/gbpb_ram.sv
module gbpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/gbpb_div.sv
// restoring divider, one quotient bit per cycle
module gbpb_div (
  input  logic                clk,
  input  logic                rst,
  input  gbpb_pkg::div_req_t  req,
  output gbpb_pkg::div_rsp_t  rsp
);

  localparam int CW = $clog2(gbpb_pkg::CUR_W + 1);

  logic [CW-1:0]                cnt;
  logic [gbpb_pkg::CUR_W-1:0]   quo;
  logic [gbpb_pkg::COL_W-1:0]   rem;
  logic [gbpb_pkg::COL_W-1:0]   dvs;
  logic [gbpb_pkg::COL_W:0]     trial;
  logic                         take;

  assign trial = {rem, quo[gbpb_pkg::CUR_W-1]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= CW'(gbpb_pkg::CUR_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (cnt != '0) begin
      quo <= {quo[gbpb_pkg::CUR_W-2:0], take};
      rem <= take ? gbpb_pkg::COL_W'(trial - {1'b0, dvs}) : trial[gbpb_pkg::COL_W-1:0];
    end
  end

  assign rsp.busy = cnt != '0;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

// File: sv/glyph_blitter_to_page_buffer_unit.sv
// channel  | dir | handshake             | payload
// s_*      | in  | s_tvalid / s_tready   | s_tdata commands, s_tuser action
// m_*      | out | m_tvalid / m_tready   | m_tdata write, m_tuser flags, m_tlast
// cfg_*    | in  | cfg_we                | cfg_index, cfg_data
// One item at a time; s_tready is high only while idle. Render runs a divider pass that
// finds the cursor column per row, then writes each byte; another pass follows when the
// cursor moves into the box, steps past its end or wraps, and on overflow. Newline and
// return also run a divider pass; they, other actions and rejects give one result.
// Results are buffered so the overflow flag is final in every result; m_tvalid holds until
// m_tready. rst is synchronous; font memory is not cleared.
module glyph_blitter_to_page_buffer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // code[7:0] font_addr[18:8] font_byte[26:19] cursor_x[34:27] cursor_y[42:35]
  // scroll_lines[50:43] invert[51] blink_enable[52] blink_phase[53]
  input  logic [55:0] s_tdata,
  // action[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // write_index[9:0] write_data[17:10]
  output logic [23:0] m_tdata,
  // write_valid[0] status[1] overflow[2]
  output logic [2:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CW = gbpb_pkg::CUR_W;
  localparam int FA = gbpb_pkg::FONT_AW;
  localparam int RA = gbpb_pkg::RES_AW;

  gbpb_pkg::state_t state, state_next, ret;

  logic [7:0] display_width, font_first_code, font_count, box_end;
  logic [3:0] display_pages, glyph_width, glyph_height;
  logic [6:0] box_begin;

  logic [7:0] w;
  logic [3:0] pages, gw, gh;

  logic [CW-1:0] cursor, scroll_off, scroll_mark, quo;
  logic          ovf_flag;
  logic [CW:0]   limit, mark_lim;
  logic [7:0]    col;
  logic [3:0]    row, colidx;
  logic [11:0]   prod;
  logic [FA-1:0] rowbase;
  logic [RA:0]   cnt;
  logic [RA-1:0] rd_ptr;
  logic          status;

  gbpb_pkg::action_t act;
  logic [7:0]    in_code, in_fbyte, in_cx, in_cy, in_lines;
  logic [FA-1:0] in_faddr;
  logic          in_inv, in_blank;

  logic [16:0] mul_a;
  logic [7:0]  mul_b;
  logic [24:0] mul_p;

  gbpb_pkg::div_req_t div_req;
  gbpb_pkg::div_rsp_t div_rsp;

  logic          font_we;
  logic [FA-1:0] font_addr;
  logic [7:0]    font_rdata, glyph_byte;
  logic          res_we;
  logic [RA-1:0] res_addr;
  logic [gbpb_pkg::RES_W-1:0] res_wdata, res_rdata;

  logic        reject, byte_ovf, emit_ok, cur_wrap, byte_done, row_last, adjust;
  logic [7:0]  col_inc, lines_eff;

  function automatic logic [gbpb_pkg::IDX_W-1:0] IDX_W_SLICE(input logic [CW-1:0] v);
    return v[gbpb_pkg::IDX_W-1:0];
  endfunction

  always_comb begin
    w     = (display_width == 8'd0) ? 8'd1 :
            (display_width > 8'(gbpb_pkg::MAX_WIDTH)) ? 8'(gbpb_pkg::MAX_WIDTH) : display_width;
    pages = (display_pages == 4'd0) ? 4'd1 :
            (display_pages > 4'(gbpb_pkg::MAX_PAGES)) ? 4'(gbpb_pkg::MAX_PAGES) : display_pages;
    gw    = (glyph_width == 4'd0) ? 4'd1 :
            (glyph_width > 4'(gbpb_pkg::MAX_GLYPH)) ? 4'(gbpb_pkg::MAX_GLYPH) : glyph_width;
    gh    = (glyph_height == 4'd0) ? 4'd1 :
            (glyph_height > 4'(gbpb_pkg::MAX_GLYPH)) ? 4'(gbpb_pkg::MAX_GLYPH) : glyph_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width   <= 8'd128;
      display_pages   <= 4'd8;
      font_first_code <= 8'd32;
      font_count      <= 8'd95;
      glyph_width     <= 4'd5;
      glyph_height    <= 4'd1;
      box_begin       <= 7'd0;
      box_end         <= 8'd128;
    end else if (cfg_we) begin
      unique case (gbpb_pkg::cfg_idx_t'(cfg_index))
        gbpb_pkg::CFG_DISPLAY_WIDTH: display_width   <= cfg_data;
        gbpb_pkg::CFG_DISPLAY_PAGES: display_pages   <= cfg_data[3:0];
        gbpb_pkg::CFG_FONT_FIRST:    font_first_code <= cfg_data;
        gbpb_pkg::CFG_FONT_COUNT:    font_count      <= cfg_data;
        gbpb_pkg::CFG_GLYPH_WIDTH:   glyph_width     <= cfg_data[3:0];
        gbpb_pkg::CFG_GLYPH_HEIGHT:  glyph_height    <= cfg_data[3:0];
        gbpb_pkg::CFG_BOX_BEGIN:     box_begin       <= cfg_data[6:0];
        gbpb_pkg::CFG_BOX_END:       box_end         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lines_eff = (in_lines > gbpb_pkg::SCROLL_MAX) ? 8'd0 : in_lines;
  assign reject    = (in_code < font_first_code) ||
                     ({1'b0, in_code} >= ({1'b0, font_first_code} + {1'b0, font_count})) ||
                     ({1'b0, box_begin} >= w);
  assign byte_ovf  = {1'b0, cursor} >= limit;
  assign emit_ok   = {1'b0, cursor} >= mark_lim;
  assign cur_wrap  = cursor == {CW{1'b1}};
  assign col_inc   = ((col + 8'd1) == w) ? 8'd0 : col + 8'd1;
  assign byte_done = ((colidx + 4'd1) == gw) || (box_end <= col_inc);
  assign row_last  = (row + 4'd1) >= gh;
  assign adjust    = ({1'b0, box_begin} > col) || (box_end == col);

  assign glyph_byte = in_blank ? gbpb_pkg::BLANK_BYTE : (in_inv ? ~font_rdata : font_rdata);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = w;
    unique case (state)
      gbpb_pkg::ST_DECODE: begin
        if (act == gbpb_pkg::ACT_CURSOR) begin
          mul_a = {9'd0, in_cy};
        end else if (act == gbpb_pkg::ACT_SCROLL) begin
          mul_a = {9'd0, lines_eff};
        end else begin
          mul_a = {13'd0, pages};
        end
      end
      gbpb_pkg::ST_BASE1: begin
        mul_a = {9'd0, 8'(in_code - font_first_code)};
        mul_b = {4'd0, gw};
      end
      gbpb_pkg::ST_BASE2: begin
        mul_a = {5'd0, prod};
        mul_b = {4'd0, gh};
      end
      gbpb_pkg::ST_NL:    mul_a = {1'b0, quo} + {13'd0, gh};
      gbpb_pkg::ST_CR,
      gbpb_pkg::ST_START: mul_a = {1'b0, quo};
      gbpb_pkg::ST_FINAL: mul_a = {13'd0, gh - 4'd1};
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gbpb_pkg::ST_IDLE:   if (s_tvalid) state_next = gbpb_pkg::ST_DECODE;
      gbpb_pkg::ST_DECODE: begin
        if (act == gbpb_pkg::ACT_RENDER) begin
          if (in_code == gbpb_pkg::CH_NEWLINE || in_code == gbpb_pkg::CH_RETURN) begin
            state_next = gbpb_pkg::ST_SYNC;
          end else if (reject) begin
            state_next = gbpb_pkg::ST_OUT;
          end else begin
            state_next = gbpb_pkg::ST_BASE1;
          end
        end else begin
          state_next = gbpb_pkg::ST_OUT;
        end
      end
      gbpb_pkg::ST_BASE1:  state_next = gbpb_pkg::ST_BASE2;
      gbpb_pkg::ST_BASE2:  state_next = gbpb_pkg::ST_SYNC;
      gbpb_pkg::ST_SYNC:   state_next = gbpb_pkg::ST_WAIT;
      gbpb_pkg::ST_WAIT:   if (!div_rsp.busy) state_next = ret;
      gbpb_pkg::ST_START:  state_next = adjust ? gbpb_pkg::ST_SYNC : gbpb_pkg::ST_FETCH;
      gbpb_pkg::ST_FETCH:  state_next = gbpb_pkg::ST_BYTE;
      gbpb_pkg::ST_BYTE: begin
        if (byte_ovf) begin
          state_next = gbpb_pkg::ST_OVF;
        end else if (cur_wrap) begin
          state_next = gbpb_pkg::ST_SYNC;
        end else if (byte_done) begin
          state_next = gbpb_pkg::ST_ROWEND;
        end
      end
      gbpb_pkg::ST_CHK: begin
        state_next = (box_end <= col || colidx == gw) ? gbpb_pkg::ST_ROWEND
                                                      : gbpb_pkg::ST_FETCH;
      end
      gbpb_pkg::ST_OVF:    state_next = gbpb_pkg::ST_SYNC;
      gbpb_pkg::ST_ROWEND: begin
        if (!row_last || (box_end == col && col != 8'd0)) begin
          state_next = gbpb_pkg::ST_SYNC;
        end else begin
          state_next = gbpb_pkg::ST_FINAL;
        end
      end
      gbpb_pkg::ST_FINAL,
      gbpb_pkg::ST_NL,
      gbpb_pkg::ST_CR:     state_next = gbpb_pkg::ST_OUT;
      gbpb_pkg::ST_OUT:    state_next = (cnt == '0) ? gbpb_pkg::ST_SEND : gbpb_pkg::ST_LD;
      gbpb_pkg::ST_LD:     state_next = gbpb_pkg::ST_SEND;
      gbpb_pkg::ST_SEND: begin
        if (m_tready) state_next = m_tlast ? gbpb_pkg::ST_IDLE : gbpb_pkg::ST_LD;
      end
      default:             state_next = gbpb_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready         = state == gbpb_pkg::ST_IDLE;
    m_tvalid         = state == gbpb_pkg::ST_SEND;
    div_req.start    = state == gbpb_pkg::ST_SYNC;
    div_req.dividend = cursor;
    div_req.divisor  = w;
    font_we          = (state == gbpb_pkg::ST_DECODE) && (act == gbpb_pkg::ACT_LOAD);
    res_we           = (state == gbpb_pkg::ST_BYTE) && !byte_ovf && emit_ok;
    res_wdata        = {glyph_byte, IDX_W_SLICE(cursor - scroll_off)};
    res_addr         = rd_ptr;
    font_addr        = rowbase + {{(FA-4){1'b0}}, colidx};
    unique case (state)
      gbpb_pkg::ST_DECODE: font_addr = in_faddr;
      gbpb_pkg::ST_BYTE: begin
        font_addr = rowbase + {{(FA-4){1'b0}}, colidx} + FA'(1);
        res_addr  = cnt[RA-1:0];
      end
      gbpb_pkg::ST_SEND:   res_addr = rd_ptr + RA'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gbpb_pkg::ST_IDLE;
      ret         <= gbpb_pkg::ST_IDLE;
      cursor      <= '0;
      scroll_off  <= '0;
      scroll_mark <= '0;
      ovf_flag    <= 1'b0;
      cnt         <= '0;
      rd_ptr      <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        gbpb_pkg::ST_DECODE: begin
          cnt    <= '0;
          rd_ptr <= '0;
          unique case (act)
            gbpb_pkg::ACT_RENDER: begin
              if (in_code == gbpb_pkg::CH_NEWLINE) begin
                ret <= gbpb_pkg::ST_NL;
              end else if (in_code == gbpb_pkg::CH_RETURN) begin
                ret <= gbpb_pkg::ST_CR;
              end
            end
            gbpb_pkg::ACT_CURSOR: cursor <= mul_p[CW-1:0] + {8'd0, in_cx};
            gbpb_pkg::ACT_SCROLL: begin
              scroll_off  <= mul_p[CW-1:0];
              scroll_mark <= cursor;
            end
            gbpb_pkg::ACT_CLEAR: begin
              cursor      <= '0;
              scroll_off  <= '0;
              scroll_mark <= '0;
              ovf_flag    <= 1'b0;
            end
            default: ;
          endcase
        end
        gbpb_pkg::ST_BASE2: ret <= gbpb_pkg::ST_START;
        gbpb_pkg::ST_START: begin
          if (adjust) begin
            cursor <= mul_p[CW-1:0] + {9'd0, box_begin};
            ret    <= gbpb_pkg::ST_FETCH;
          end
        end
        gbpb_pkg::ST_BYTE: begin
          if (byte_ovf) begin
            ovf_flag <= 1'b1;
          end else begin
            if (emit_ok) cnt <= cnt + (RA+1)'(1);
            cursor <= cursor + CW'(1);
            ret    <= gbpb_pkg::ST_CHK;
          end
        end
        gbpb_pkg::ST_OVF: begin
          cursor <= cursor + {12'd0, gw - colidx};
          ret    <= gbpb_pkg::ST_ROWEND;
        end
        gbpb_pkg::ST_ROWEND: begin
          if (!row_last) begin
            cursor <= cursor - {12'd0, colidx} + {8'd0, w};
            ret    <= gbpb_pkg::ST_FETCH;
          end else if (box_end == col && col != 8'd0) begin
            cursor <= cursor + {8'd0, w};
            ret    <= gbpb_pkg::ST_FINAL;
          end
        end
        gbpb_pkg::ST_FINAL: if (box_end != col) cursor <= cursor - mul_p[CW-1:0];
        gbpb_pkg::ST_NL:    cursor <= mul_p[CW-1:0] + {8'd0, col};
        gbpb_pkg::ST_CR:    cursor <= mul_p[CW-1:0];
        gbpb_pkg::ST_SEND:  if (m_tready) rd_ptr <= rd_ptr + RA'(1);
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (state == gbpb_pkg::ST_IDLE && s_tvalid) begin
      act      <= gbpb_pkg::action_t'(s_tuser);
      in_code  <= s_tdata[7:0];
      in_faddr <= s_tdata[18:8];
      in_fbyte <= s_tdata[26:19];
      in_cx    <= s_tdata[34:27];
      in_cy    <= s_tdata[42:35];
      in_lines <= s_tdata[50:43];
      in_inv   <= s_tdata[51];
      in_blank <= s_tdata[52] & s_tdata[53];
    end
    unique case (state)
      gbpb_pkg::ST_DECODE: begin
        status   <= (act == gbpb_pkg::ACT_RENDER) && reject &&
                    in_code != gbpb_pkg::CH_NEWLINE && in_code != gbpb_pkg::CH_RETURN;
        limit    <= {1'b0, mul_p[CW-1:0]} + {1'b0, scroll_off};
        mark_lim <= {1'b0, scroll_off} + {1'b0, scroll_mark};
      end
      gbpb_pkg::ST_BASE1: prod <= mul_p[11:0];
      gbpb_pkg::ST_BASE2: begin
        rowbase <= mul_p[FA-1:0];
        row     <= 4'd0;
        colidx  <= 4'd0;
      end
      gbpb_pkg::ST_WAIT: begin
        col <= div_rsp.rem;
        quo <= div_rsp.quo;
      end
      gbpb_pkg::ST_BYTE: begin
        if (!byte_ovf) begin
          colidx <= colidx + 4'd1;
          col    <= col_inc;
        end
      end
      gbpb_pkg::ST_ROWEND: begin
        if (!row_last) begin
          row     <= row + 4'd1;
          rowbase <= rowbase + {{(FA-4){1'b0}}, gw};
          colidx  <= 4'd0;
        end
      end
      gbpb_pkg::ST_OUT: begin
        if (cnt == '0) begin
          m_tdata    <= '0;
          m_tuser[0] <= 1'b0;
          m_tlast    <= 1'b1;
        end
        m_tuser[1] <= status;
        m_tuser[2] <= ovf_flag;
      end
      gbpb_pkg::ST_LD: begin
        m_tdata    <= {6'd0, res_rdata};
        m_tuser[0] <= 1'b1;
        m_tlast    <= {1'b0, rd_ptr} == cnt - (RA+1)'(1);
      end
      default: ;
    endcase
  end

  gbpb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  gbpb_ram #(
    .WIDTH (8),
    .DEPTH (gbpb_pkg::FONT_BYTES)
  ) u_font (
    .clk   (clk),
    .we    (font_we),
    .addr  (font_addr),
    .wdata (in_fbyte),
    .rdata (font_rdata)
  );

  gbpb_ram #(
    .WIDTH (gbpb_pkg::RES_W),
    .DEPTH (gbpb_pkg::RES_DEPTH)
  ) u_res (
    .clk   (clk),
    .we    (res_we),
    .addr  (res_addr),
    .wdata (res_wdata),
    .rdata (res_rdata)
  );

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk) disable iff (rst) s_tready |-> !m_tvalid)
    else $error("input taken while a result is pending");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == gbpb_pkg::ST_SYNC |-> !div_rsp.busy)
    else $error("divider restarted while busy");
  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= (RA+1)'(gbpb_pkg::RES_DEPTH))
    else $error("result buffer overrun");
`endif

endmodule
